// File: sv/tlfg_pkg.sv
// tlfg_pkg: shared types, constants and helpers of the trilinear lorentz force gather
// no dependencies; used by trilinear_lorentz_force_gather
`timescale 1ns / 1ps
package tlfg_pkg;

  localparam int CELL_COUNT = 4096;
  localparam int AXIS_LIMIT = 16;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int IDX_W      = $clog2(AXIS_LIMIT);
  localparam int VEC_W      = 96;

  typedef enum logic [1:0] {
    MODE_WR_E  = 2'd0,
    MODE_WR_H  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  localparam logic [3:0] CFG_SIZE_X   = 4'd0;
  localparam logic [3:0] CFG_SIZE_Y   = 4'd1;
  localparam logic [3:0] CFG_SIZE_Z   = 4'd2;
  localparam logic [3:0] CFG_ORIGIN_X = 4'd3;
  localparam logic [3:0] CFG_ORIGIN_Y = 4'd4;
  localparam logic [3:0] CFG_ORIGIN_Z = 4'd5;
  localparam logic [3:0] CFG_INV_SP   = 4'd6;
  localparam logic [3:0] CFG_PERM     = 4'd7;

  // clamp to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    logic signed [31:0] r;
    if (v > 96'sd2147483647) r = 32'sh7fffffff;
    else if (v < -96'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // grid points in use, forced into 2..AXIS_LIMIT
  function automatic logic [4:0] eff_size(input logic [4:0] s);
    logic [4:0] r;
    if (s < 5'd2) r = 5'd2;
    else if (s > 5'(AXIS_LIMIT)) r = 5'(AXIS_LIMIT);
    else r = s;
    return r;
  endfunction

endpackage

// File: sv/tlfg_ram.sv
// tlfg_ram: generic ram, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
module tlfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: sv/trilinear_lorentz_force_gather.sv
// trilinear_lorentz_force_gather: field grid store and pipelined lorentz force gather
// depends on tlfg_pkg and tlfg_ram
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  ------------------------------------------------------------------------------------
//  command   in         start / busy (busy low)    mode, cell_index, field_*, pos_*,
//                                                  vel_*, charge
//  result    out        done_o, one-cycle strobe   force_x_o, force_y_o, force_z_o
//  config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  one word is taken every cycle; busy and cfg_ready_o are constant
//  a query's force word is on the result ports once it has passed the input register and
//  twelve more stages, and is taken at the edge after that; writes give no word and
//  land in the field rams from stage 3, the same stage at which queries read, so
//  program order holds
//  the rate is set by the eight-corner read: every field ram is held four times,
//  each copy with two read ports, so all 8 corners are read together
//  reset clears the valid bits and sets the configuration registers to their defaults;
//  field rams are undefined until written; the receiver cannot stall, so nothing ever waits
module trilinear_lorentz_force_gather (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode_i,
  input  logic [11:0]         cell_index_i,
  input  logic signed [31:0]  field_x_i,
  input  logic signed [31:0]  field_y_i,
  input  logic signed [31:0]  field_z_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  vel_z_i,
  input  logic signed [31:0]  charge_i,
  output logic                done_o,
  output logic signed [31:0]  force_x_o,
  output logic signed [31:0]  force_y_o,
  output logic signed [31:0]  force_z_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import tlfg_pkg::*;

  // ---------------------------------------------------------------- config
  logic [4:0]         size_q [3];
  logic signed [31:0] origin_q [3];
  logic [31:0]        inv_sp_q;
  logic signed [31:0] perm_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        size_q[a]   <= 5'd16;
        origin_q[a] <= '0;
      end
      inv_sp_q <= 32'd65536;
      perm_q   <= 32'sd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SIZE_X:   size_q[0]   <= cfg_data_i[4:0];
        CFG_SIZE_Y:   size_q[1]   <= cfg_data_i[4:0];
        CFG_SIZE_Z:   size_q[2]   <= cfg_data_i[4:0];
        CFG_ORIGIN_X: origin_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y: origin_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z: origin_q[2] <= cfg_data_i;
        CFG_INV_SP:   inv_sp_q    <= cfg_data_i;
        CFG_PERM:     perm_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [4:0] nsz [3];
  logic [8:0] nxny;
  always_comb begin
    for (int a = 0; a < 3; a++) nsz[a] = eff_size(size_q[a]);
    nxny = 9'(nsz[0] * nsz[1]);
  end

  // ---------------------------------------------------------------- valid bits
  logic       v0_q, v1_q, v2_q, v3_q;
  mode_e      mode0_q, mode1_q, mode2_q, mode3_q;
  logic [8:0] qv_q;   // query valid, stages 4 to 12

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      qv_q <= '0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      qv_q <= {qv_q[7:0], v3_q && (mode3_q == MODE_QUERY)};
    end
  end

  // ---------------------------------------------------------------- payload stages
  logic [ADDR_W-1:0]  ci0_q, ci1_q, ci2_q, ci3_q;
  logic [VEC_W-1:0]   fld0_q, fld1_q, fld2_q, fld3_q;
  logic signed [31:0] pos0_q [3];
  logic signed [31:0] vel0_q [3], vel1_q [3], vel2_q [3], vel3_q [3];
  logic signed [31:0] vel4_q [3], vel5_q [3], vel6_q [3], vel7_q [3], vel8_q [3];
  logic signed [31:0] chg0_q, chg1_q, chg2_q, chg3_q, chg4_q, chg5_q;
  logic signed [31:0] chg6_q, chg7_q, chg8_q, chg9_q, chg10_q;

  // stage 1: position to grid units, raw product
  logic signed [65:0] gp1_d [3];
  logic signed [65:0] gp1_q [3];
  // stage 2: clamped corner index and weight pair
  logic [IDX_W-1:0]   idx2_d [3];
  logic signed [31:0] wt2_d [3][2];
  logic [IDX_W-1:0]   idx2_q [3];
  logic signed [31:0] wt2_q [3][2];
  // stage 3: xy weight products and corner addresses, ram access
  logic signed [63:0] pxy3_d [4];
  logic [ADDR_W-1:0]  addr3_d [8];
  logic signed [63:0] pxy3_q [4];
  logic [ADDR_W-1:0]  addr3_q [8];
  logic signed [31:0] az3_q [2];
  // stage 4: full corner weight products, ram data arrives
  logic signed [63:0] pw4_d [8];
  logic signed [63:0] pw4_q [8];
  // stage 5: weighted cell terms, e x/y/z then h x/y/z
  logic signed [47:0] term5_d [6][8];
  logic signed [47:0] term5_q [6][8];
  // stage 6 and 7: adder tree
  logic signed [49:0] part6_d [6][2];
  logic signed [49:0] part6_q [6][2];
  logic signed [31:0] fv7_d [6];
  logic signed [31:0] fv7_q [6];
  // stage 8: h times permeability
  logic signed [63:0] bp8_d [3];
  logic signed [63:0] bp8_q [3];
  logic signed [31:0] e8_q [3];
  // stage 9: velocity cross products
  logic signed [31:0] b9 [3];
  logic signed [63:0] cp9_d [6];
  logic signed [63:0] cp9_q [6];
  logic signed [31:0] e9_q [3];
  // stage 10: e plus cross term
  logic signed [49:0] s10_d [3];
  logic signed [49:0] s10_q [3];
  // stage 11: charge times sum, split in two partial products
  logic signed [56:0] hi11_d [3];
  logic signed [57:0] lo11_d [3];
  logic signed [56:0] hi11_q [3];
  logic signed [57:0] lo11_q [3];
  // stage 12: output register
  logic signed [31:0] force_d [3];
  logic signed [31:0] force_q [3];

  // field ram read data, one per corner
  logic [VEC_W-1:0] e_rd [8];
  logic [VEC_W-1:0] h_rd [8];

  always_comb begin
    logic signed [32:0] dpos;
    logic signed [32:0] inv_s;
    logic signed [31:0] g;
    logic signed [16:0] fl;
    logic signed [16:0] hi;
    logic [IDX_W-1:0]   ix;
    logic signed [31:0] wxy [4];
    logic signed [31:0] wc [8];
    logic signed [31:0] cellv;
    logic signed [63:0] prod;
    logic signed [64:0] diff;
    logic signed [48:0] xterm;
    logic [12:0]        lin;
    logic [IDX_W:0]     ci, cj, ck;

    inv_s = signed'({1'b0, inv_sp_q});
    for (int a = 0; a < 3; a++) begin
      dpos     = 33'(pos0_q[a]) - 33'(origin_q[a]);
      gp1_d[a] = 66'(dpos) * 66'(inv_s);
    end

    for (int a = 0; a < 3; a++) begin
      g  = sat32(96'(gp1_q[a] >>> 16));
      fl = 17'(g >>> 16);
      hi = signed'(17'(nsz[a])) - 17'sd2;
      if (fl < 17'sd0) ix = '0;
      else if (fl > hi) ix = hi[IDX_W-1:0];
      else ix = fl[IDX_W-1:0];
      idx2_d[a]    = ix;
      wt2_d[a][1]  = sat32(96'(g) - 96'(signed'({1'b0, ix, 16'b0})));
      wt2_d[a][0]  = sat32(96'sd65536 - 96'(wt2_d[a][1]));
    end

    for (int c = 0; c < 4; c++) begin
      pxy3_d[c] = 64'(wt2_q[0][(c >> 1) & 1]) * 64'(wt2_q[1][c & 1]);
    end
    for (int c = 0; c < 8; c++) begin
      ci  = (IDX_W + 1)'(idx2_q[0]) + (IDX_W + 1)'((c >> 2) & 1);
      cj  = (IDX_W + 1)'(idx2_q[1]) + (IDX_W + 1)'((c >> 1) & 1);
      ck  = (IDX_W + 1)'(idx2_q[2]) + (IDX_W + 1)'(c & 1);
      lin = 13'(ck * nxny) + 13'(cj * nsz[0]) + 13'(ci);
      addr3_d[c] = lin[ADDR_W-1:0];
    end

    for (int c = 0; c < 4; c++) wxy[c] = sat32(96'(pxy3_q[c] >>> 16));
    for (int c = 0; c < 8; c++) begin
      pw4_d[c] = 64'(wxy[c >> 1]) * 64'(az3_q[c & 1]);
    end

    for (int c = 0; c < 8; c++) wc[c] = sat32(96'(pw4_q[c] >>> 16));
    for (int f = 0; f < 3; f++) begin
      for (int c = 0; c < 8; c++) begin
        cellv          = e_rd[c][32*f +: 32];
        prod           = 64'(wc[c]) * 64'(cellv);
        term5_d[f][c]  = prod[63:16];
        cellv          = h_rd[c][32*f +: 32];
        prod           = 64'(wc[c]) * 64'(cellv);
        term5_d[f+3][c] = prod[63:16];
      end
    end

    for (int f = 0; f < 6; f++) begin
      for (int h = 0; h < 2; h++) begin
        part6_d[f][h] = 50'(term5_q[f][4*h])   + 50'(term5_q[f][4*h+1])
                      + 50'(term5_q[f][4*h+2]) + 50'(term5_q[f][4*h+3]);
      end
      fv7_d[f] = sat32(96'(51'(part6_q[f][0]) + 51'(part6_q[f][1])));
    end

    for (int a = 0; a < 3; a++) bp8_d[a] = 64'(fv7_q[a+3]) * 64'(perm_q);

    for (int a = 0; a < 3; a++) b9[a] = sat32(96'(bp8_q[a] >>> 16));
    cp9_d[0] = 64'(vel8_q[1]) * 64'(b9[2]);
    cp9_d[1] = 64'(vel8_q[2]) * 64'(b9[1]);
    cp9_d[2] = 64'(vel8_q[2]) * 64'(b9[0]);
    cp9_d[3] = 64'(vel8_q[0]) * 64'(b9[2]);
    cp9_d[4] = 64'(vel8_q[0]) * 64'(b9[1]);
    cp9_d[5] = 64'(vel8_q[1]) * 64'(b9[0]);

    for (int f = 0; f < 3; f++) begin
      diff     = 65'(cp9_q[2*f]) - 65'(cp9_q[2*f+1]);
      xterm    = diff[64:16];
      s10_d[f] = 50'(e9_q[f]) + 50'(xterm);
    end

    for (int f = 0; f < 3; f++) begin
      hi11_d[f] = 57'(chg10_q) * 57'(signed'(s10_q[f][49:25]));
      lo11_d[f] = 58'(chg10_q) * 58'(signed'({1'b0, s10_q[f][24:0]}));
    end

    for (int f = 0; f < 3; f++) begin
      force_d[f] = sat32(96'((82'(hi11_q[f]) <<< 25) + 82'(lo11_q[f])) >>> 16);
    end
  end

  always_ff @(posedge clk_i) begin
    mode0_q <= mode_e'(mode_i);
    ci0_q   <= cell_index_i;
    fld0_q  <= {field_z_i, field_y_i, field_x_i};
    pos0_q  <= '{pos_x_i, pos_y_i, pos_z_i};
    vel0_q  <= '{vel_x_i, vel_y_i, vel_z_i};
    chg0_q  <= charge_i;

    mode1_q <= mode0_q;  ci1_q <= ci0_q;  fld1_q <= fld0_q;
    mode2_q <= mode1_q;  ci2_q <= ci1_q;  fld2_q <= fld1_q;
    mode3_q <= mode2_q;  ci3_q <= ci2_q;  fld3_q <= fld2_q;

    vel1_q <= vel0_q;  vel2_q <= vel1_q;  vel3_q <= vel2_q;  vel4_q <= vel3_q;
    vel5_q <= vel4_q;  vel6_q <= vel5_q;  vel7_q <= vel6_q;  vel8_q <= vel7_q;
    chg1_q <= chg0_q;  chg2_q <= chg1_q;  chg3_q <= chg2_q;  chg4_q <= chg3_q;
    chg5_q <= chg4_q;  chg6_q <= chg5_q;  chg7_q <= chg6_q;  chg8_q <= chg7_q;
    chg9_q <= chg8_q;  chg10_q <= chg9_q;

    gp1_q   <= gp1_d;
    idx2_q  <= idx2_d;
    wt2_q   <= wt2_d;
    pxy3_q  <= pxy3_d;
    addr3_q <= addr3_d;
    az3_q   <= wt2_q[2];
    pw4_q   <= pw4_d;
    term5_q <= term5_d;
    part6_q <= part6_d;
    fv7_q   <= fv7_d;
    bp8_q   <= bp8_d;
    e8_q    <= fv7_q[0:2];
    cp9_q   <= cp9_d;
    e9_q    <= e8_q;
    s10_q   <= s10_d;
    hi11_q  <= hi11_d;
    lo11_q  <= lo11_d;
    force_q <= force_d;
  end

  // ---------------------------------------------------------------- field rams
  // writes and corner reads both happen while the item sits in stage 3
  logic we_e, we_h;
  assign we_e = v3_q && (mode3_q == MODE_WR_E);
  assign we_h = v3_q && (mode3_q == MODE_WR_H);

  for (genvar r = 0; r < 4; r++) begin : g_copy
    tlfg_ram #(
      .WIDTH (VEC_W),
      .DEPTH (CELL_COUNT)
    ) u_e_ram (
      .clk_i     (clk_i),
      .we_i      (we_e),
      .waddr_i   (ci3_q),
      .wdata_i   (fld3_q),
      .raddr_a_i (addr3_q[2*r]),
      .raddr_b_i (addr3_q[2*r+1]),
      .rdata_a_o (e_rd[2*r]),
      .rdata_b_o (e_rd[2*r+1])
    );
    tlfg_ram #(
      .WIDTH (VEC_W),
      .DEPTH (CELL_COUNT)
    ) u_h_ram (
      .clk_i     (clk_i),
      .we_i      (we_h),
      .waddr_i   (ci3_q),
      .wdata_i   (fld3_q),
      .raddr_a_i (addr3_q[2*r]),
      .raddr_b_i (addr3_q[2*r+1]),
      .rdata_a_o (h_rd[2*r]),
      .rdata_b_o (h_rd[2*r+1])
    );
  end

  // ---------------------------------------------------------------- result
  assign done_o    = qv_q[8];
  assign force_x_o = force_q[0];
  assign force_y_o = force_q[1];
  assign force_z_o = force_q[2];

endmodule

// File: dv/tb_top.sv
// tb_top: self-checking bench for the trilinear lorentz force gather
// drives commands and register writes, predicts every force word and checks it
// depends on tlfg_pkg and trilinear_lorentz_force_gather
`timescale 1ns / 1ps
module tb_top;
  import tlfg_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    mode_e              mode;
    logic [11:0]        cell_idx;
    logic signed [31:0] fx, fy, fz;
    logic signed [31:0] px, py, pz;
    logic signed [31:0] vx, vy, vz;
    logic signed [31:0] chg;
  } cmd_t;

  typedef struct {
    logic signed [31:0] x, y, z;
  } force_t;

  logic clk_i, rst_ni;
  logic start, busy;
  logic [1:0] mode_i;
  logic [11:0] cell_index_i;
  logic signed [31:0] field_x_i, field_y_i, field_z_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [31:0] vel_x_i, vel_y_i, vel_z_i, charge_i;
  logic done_o;
  logic signed [31:0] force_x_o, force_y_o, force_z_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [3:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  trilinear_lorentz_force_gather dut (.*);

  // shadow of the field grid and the register file
  logic signed [31:0] e_grid [3][CELL_COUNT];
  logic signed [31:0] h_grid [3][CELL_COUNT];
  logic [4:0]         sz_reg [3];
  logic signed [31:0] org_reg [3];
  logic [31:0]        inv_sp;
  logic signed [31:0] perm;

  cmd_t   pending_cmds[$];
  force_t forces_due[$];
  cmd_t   cur;
  int     gap_pct;
  int     errors, n_queries, n_checked, cycles;

  localparam int CYCLE_LIMIT = 600000;
  // every grid setting below spans at most this many points
  localparam int FILL_CELLS  = 256;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic enqueue(input cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // ---------------------------------------------------------------- arithmetic
  function automatic wide_t clip32(input wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // q16.16 product, floored then clipped (wide enough that the raw product never wraps)
  function automatic wide_t qmul(input wide_t a, input wide_t b);
    return clip32((a * b) >>> 16);
  endfunction

  function automatic int axis_pts(input logic [4:0] s);
    if (s < 2) return 2;
    if (s > AXIS_LIMIT) return AXIS_LIMIT;
    return int'(s);
  endfunction

  // lower corner index and the two weights along one axis
  function automatic void axis_weights(input wide_t pos, input wide_t org, input int n,
                                       output int idx, output wide_t w0, output wide_t w1);
    wide_t g, i;
    g = qmul(pos - org, wide_t'({96'd0, inv_sp}));
    i = g >>> 16;
    if (i > n - 2) i = n - 2;
    if (i < 0) i = 0;
    w1 = clip32(g - i * 65536);
    w0 = clip32(65536 - w1);
    idx = int'(i);
  endfunction

  function automatic wide_t blend(input bit magnetic, input int comp,
                                  input wide_t wgt[8], input int cix[8]);
    wide_t acc;
    acc = 0;
    for (int c = 0; c < 8; c++) begin
      if (cix[c] >= 0 && cix[c] < CELL_COUNT)
        acc += (wgt[c] * wide_t'(magnetic ? h_grid[comp][cix[c]] : e_grid[comp][cix[c]])) >>> 16;
    end
    return clip32(acc);
  endfunction

  function automatic force_t lorentz_force(input cmd_t c);
    int nx, ny, nz, i, j, k;
    wide_t ax[2], ay[2], az[2], wgt[8], e[3], b[3], v0, v1, v2, q;
    int cix[8];
    force_t r;
    nx = axis_pts(sz_reg[0]);
    ny = axis_pts(sz_reg[1]);
    nz = axis_pts(sz_reg[2]);
    axis_weights(wide_t'(c.px), wide_t'(org_reg[0]), nx, i, ax[0], ax[1]);
    axis_weights(wide_t'(c.py), wide_t'(org_reg[1]), ny, j, ay[0], ay[1]);
    axis_weights(wide_t'(c.pz), wide_t'(org_reg[2]), nz, k, az[0], az[1]);
    for (int n = 0; n < 8; n++) begin
      wgt[n] = qmul(qmul(ax[(n >> 2) & 1], ay[(n >> 1) & 1]), az[n & 1]);
      cix[n] = (k + (n & 1)) * nx * ny + (j + ((n >> 1) & 1)) * nx + i + ((n >> 2) & 1);
    end
    for (int a = 0; a < 3; a++) begin
      e[a] = blend(1'b0, a, wgt, cix);
      b[a] = qmul(blend(1'b1, a, wgt, cix), wide_t'(perm));
    end
    v0 = wide_t'(c.vx);
    v1 = wide_t'(c.vy);
    v2 = wide_t'(c.vz);
    q  = wide_t'(c.chg);
    r.x = 32'(qmul(q, e[0] + ((v1 * b[2] - v2 * b[1]) >>> 16)));
    r.y = 32'(qmul(q, e[1] + ((v2 * b[0] - v0 * b[2]) >>> 16)));
    r.z = 32'(qmul(q, e[2] + ((v0 * b[1] - v1 * b[0]) >>> 16)));
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // word taken at this edge: update shadow grid or queue its force
        case (cur.mode)
          MODE_WR_E: begin
            e_grid[0][cur.cell_idx] = cur.fx;
            e_grid[1][cur.cell_idx] = cur.fy;
            e_grid[2][cur.cell_idx] = cur.fz;
          end
          MODE_WR_H: begin
            h_grid[0][cur.cell_idx] = cur.fx;
            h_grid[1][cur.cell_idx] = cur.fy;
            h_grid[2][cur.cell_idx] = cur.fz;
          end
          MODE_QUERY: begin
            forces_due.insert(forces_due.size(), lorentz_force(cur));
            n_queries++;
          end
          default: ;
        endcase
      end
      if ((!start || !busy) ) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cur = pending_cmds.pop_front();
          mode_i       <= cur.mode;
          cell_index_i <= cur.cell_idx;
          field_x_i    <= cur.fx;
          field_y_i    <= cur.fy;
          field_z_i    <= cur.fz;
          pos_x_i      <= cur.px;
          pos_y_i      <= cur.py;
          pos_z_i      <= cur.pz;
          vel_x_i      <= cur.vx;
          vel_y_i      <= cur.vy;
          vel_z_i      <= cur.vz;
          charge_i     <= cur.chg;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (forces_due.size() == 0) begin
        $display("%0t: force word with nothing expected: %h %h %h", $time,
                 force_x_o, force_y_o, force_z_o);
        errors++;
      end else begin
        force_t w;
        w = forces_due.pop_front();
        if (force_x_o !== w.x) begin
          $display("%0t: force_x expected %h actual %h", $time, w.x, force_x_o);
          errors++;
        end
        if (force_y_o !== w.y) begin
          $display("%0t: force_y expected %h actual %h", $time, w.y, force_y_o);
          errors++;
        end
        if (force_z_o !== w.z) begin
          $display("%0t: force_z expected %h actual %h", $time, w.z, force_z_o);
          errors++;
        end
        n_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, forces_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] rand_field();
    if ($urandom_range(9) < 8) return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    return $urandom;
  endfunction

  // mostly near or on the grid, now and then anywhere
  function automatic logic signed [31:0] rand_pos(input int a);
    longint gu, d;
    if ($urandom_range(9) < 7 && inv_sp != 0) begin
      gu = longint'($urandom_range(0, (axis_pts(sz_reg[a]) + 1) * 256)) - 256;
      d  = (gu * 256 * 65536) / longint'(inv_sp);
      return 32'(longint'(org_reg[a]) + d);
    end
    return $urandom;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    r = $urandom_range(99);
    c.mode = r < 15 ? MODE_WR_E : r < 30 ? MODE_WR_H : r < 95 ? MODE_QUERY : MODE_NONE;
    c.cell_idx = $urandom;
    c.fx = rand_field();
    c.fy = rand_field();
    c.fz = rand_field();
    c.px = rand_pos(0);
    c.py = rand_pos(1);
    c.pz = rand_pos(2);
    c.vx = rand_field();
    c.vy = rand_field();
    c.vz = rand_field();
    c.chg = rand_field();
    return c;
  endfunction

  function automatic cmd_t query(input logic signed [31:0] px, py, pz, vx, vy, vz, q);
    cmd_t c;
    c = rand_cmd();
    c.mode = MODE_QUERY;
    c.px = px; c.py = py; c.pz = pz;
    c.vx = vx; c.vy = vy; c.vz = vz;
    c.chg = q;
    return c;
  endfunction

  task automatic run_random(input int n);
    repeat (n) enqueue(rand_cmd());
  endtask

  // drain everything, then let the pipeline settle before touching registers
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || forces_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [3:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SIZE_X:   sz_reg[0] = data[4:0];
      CFG_SIZE_Y:   sz_reg[1] = data[4:0];
      CFG_SIZE_Z:   sz_reg[2] = data[4:0];
      CFG_ORIGIN_X: org_reg[0] = data;
      CFG_ORIGIN_Y: org_reg[1] = data;
      CFG_ORIGIN_Z: org_reg[2] = data;
      CFG_INV_SP:   inv_sp = data;
      CFG_PERM:     perm = data;
      default: ;  // unknown index, no effect
    endcase
  endtask

  task automatic set_grid(input logic [31:0] sx, sy, sz, ox, oy, oz, inv, mu);
    reg_write(CFG_SIZE_X, sx);
    reg_write(CFG_SIZE_Y, sy);
    reg_write(CFG_SIZE_Z, sz);
    reg_write(CFG_ORIGIN_X, ox);
    reg_write(CFG_ORIGIN_Y, oy);
    reg_write(CFG_ORIGIN_Z, oz);
    reg_write(CFG_INV_SP, inv);
    reg_write(CFG_PERM, mu);
  endtask

  initial begin
    cmd_t c;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = MODE_NONE;
    cell_index_i = '0;
    {field_x_i, field_y_i, field_z_i} = '0;
    {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, charge_i} = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    sz_reg = '{5'd16, 5'd16, 5'd16};
    org_reg = '{0, 0, 0};
    inv_sp = 32'h00010000;
    perm = ONE;
    errors = 0;
    n_queries = 0;
    n_checked = 0;
    cycles = 0;
    gap_pct = 29;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 16 x 4 x 4 points, the other registers keep their reset values
    reg_write(CFG_SIZE_Y, 32'd4);
    reg_write(CFG_SIZE_Z, 32'd4);

    // the cells every grid setting can reach, written once in both grids so no
    // query ever reads an empty cell
    for (int m = 0; m < 2; m++) begin
      for (int n = 0; n < FILL_CELLS; n++) begin
        c = rand_cmd();
        c.mode = m == 0 ? MODE_WR_E : MODE_WR_H;
        c.cell_idx = 12'(n);
        enqueue(c);
      end
    end

    // directed: grid corners, far outside the domain, extreme velocity and charge
    enqueue(query(0, 0, 0, ONE, ONE, ONE, ONE));
    enqueue(query(15 << 16, 15 << 16, 15 << 16, -ONE, 2 * ONE, 0, ONE));
    enqueue(query(32'sh00078000, 32'sh00030000, 32'sh000c4000, 0, 0, 0, -ONE));
    enqueue(query(QMAX, QMAX, QMAX, ONE, ONE, ONE, ONE));
    enqueue(query(QMIN, QMIN, QMIN, ONE, ONE, ONE, ONE));
    enqueue(query(-ONE, 20 << 16, 3 << 16, QMAX, QMIN, QMAX, ONE));
    enqueue(query(ONE, ONE, ONE, QMIN, QMIN, QMIN, QMAX));
    enqueue(query(2 * ONE, 5 * ONE, 9 * ONE, QMAX, QMAX, QMAX, QMIN));
    enqueue(query(QMIN, QMAX, 0, QMIN, QMAX, -1, -1));
    enqueue(query(-1, -1, -1, 0, 0, 0, 0));
    c = rand_cmd();
    c.mode = MODE_NONE;  // unused mode, no word back
    enqueue(c);
    c = rand_cmd();
    c.mode = MODE_WR_E;  // extreme field values into cells then read back around them
    c.cell_idx = 0;
    c.fx = QMAX; c.fy = QMIN; c.fz = -1;
    enqueue(c);
    c.mode = MODE_WR_H;
    c.fx = QMIN; c.fy = QMAX; c.fz = QMAX;
    enqueue(c);
    c.cell_idx = 12'hfff;
    enqueue(c);
    enqueue(query(0, 0, 0, 3 * ONE, -ONE, ONE, 2 * ONE));
    enqueue(query(15 << 16, 15 << 16, 15 << 16, QMAX, QMIN, 7, ONE));
    enqueue(query(32'sh00008000, 0, 0, ONE, ONE, ONE, QMAX));
    run_random(200);
    wait_idle();

    // smallest grid with extreme origin, spacing and permeability
    set_grid(2, 2, 2, 32'h80000000, 32'h7fffffff, 0, 32'd1, 32'h80000000);
    run_random(150);
    wait_idle();
    set_grid(4, 16, 4, $urandom, $urandom, $urandom, 32'hffffffff, 32'h7fffffff);
    run_random(80);
    wait_idle();

    // sizes outside the allowed range, zero spacing, unknown register indexes
    gap_pct = 87;
    set_grid(0, 1, 31, 32'hfff00000, 32'h00040000, 32'hffff8000, 32'd0, 32'h00020000);
    reg_write(4'd8, $urandom);
    reg_write(4'd15, $urandom);
    run_random(120);
    wait_idle();
    set_grid(5, 16, 3, 32'hfffe0000, 32'h00010000, 32'h00000000, 32'h00020000, 32'hffff0000);
    run_random(150);
    wait_idle();

    // no gaps at all, random mid-range settings
    gap_pct = 0;
    set_grid($urandom_range(2, 16), $urandom_range(2, 4), $urandom_range(2, 4),
             $urandom, $urandom, $urandom, $urandom_range(1 << 14, 1 << 18), $urandom);
    run_random(130);
    wait_idle();
    set_grid(7, 9, 4, 32'h00010000, 32'hffff0000, 32'h0, 32'h00010000, 32'h00010000);
    run_random(130);
    wait_idle();

    $display("covered %0d force queries (%0d checked) over seven grid settings", n_queries,
             n_checked);
    $display("with sender gaps of 29, 87 and 0 percent");
    if (errors == 0 && forces_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
